/* rtl/polyphonic_decay_voice_mixer_assert.svh */
// Assertion macros used by the checker.
`ifndef POLYPHONIC_DECAY_VOICE_MIXER_ASSERT_SVH
`define POLYPHONIC_DECAY_VOICE_MIXER_ASSERT_SVH

// checked outside reset
`define PDVM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pdvm check failed");

// checked at every edge, reset included
`define PDVM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pdvm check failed");

`endif

/* rtl/pdvm_pkg.sv */
package pdvm_pkg;

  localparam int MAX_VOICES_DEF = 32;
  localparam int SINE_DEPTH_DEF = 256;

  localparam int MAX_PITCH_W   = 15;
  localparam int SAMPLE_RATE_W = 18;
  localparam int VOLUME_W      = 16;
  localparam int PITCH_W       = 16;
  localparam int DURATION_W    = 24;
  localparam int SAMPLE_W      = 16;
  localparam int LIVE_W        = 6;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;

  localparam logic [MAX_PITCH_W-1:0]   MAX_PITCH_RST   = 15'd1320;
  localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RST = 18'd44100;

  // phase step dividend is max_pitch * pitch << 16
  localparam int DIV_W     = MAX_PITCH_W + PITCH_W + 16;
  localparam int DIV_CNT_W = 6;
  localparam int PHASE_W   = 32;
  localparam int ENV_W     = 26;
  localparam int DECAY_W   = 25;
  localparam int ENV_ONE   = 1 << 24;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_MUL,
    ST_PUSH_DIV,
    ST_TICK,
    ST_TICK_SAT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic                  shape;
    logic [VOLUME_W-1:0]   volume;
    logic [PITCH_W-1:0]    pitch;
    logic [DURATION_W-1:0] duration;
  } item_t;

  typedef struct packed {
    logic [MAX_PITCH_W-1:0]   max_pitch;
    logic [SAMPLE_RATE_W-1:0] sample_rate;
  } cfg_t;

  typedef struct packed {
    logic                     shape;
    logic [VOLUME_W-1:0]      gain;
    logic [PHASE_W-1:0]       phase;
    logic [PHASE_W-1:0]       step;
    logic signed [ENV_W-1:0]  env;
    logic [DECAY_W-1:0]       decay;
  } voice_t;

  // Quarter-wave entry from x = angle in Q2.30, Taylor series to x^15.
  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    logic signed [63:0] s;
    x2 = (x * x) >> 30;
    term = x;
    s = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) s = s - $signed(term);
      else s = s + $signed(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    v = (64'(s) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[14:0];
  endfunction

endpackage

/* rtl/pdvm_ram.sv */
module pdvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pdvm_front.sv */
module pdvm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pdvm_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [0:0]                          s_tuser,
  output logic                                item_valid,
  input  logic                                item_ready,
  output pdvm_pkg::item_t                     item
);

  pdvm_pkg::item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  pdvm_pkg::item_t in_item;

  always_comb begin
    in_item.op       = pdvm_pkg::op_t'(s_tuser);
    in_item.shape    = s_tdata[0];
    in_item.volume   = s_tdata[16:1];
    in_item.pitch    = s_tdata[32:17];
    in_item.duration = s_tdata[56:33];
  end

  assign s_tready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_item;
  end

endmodule

/* rtl/pdvm_back.sv */
module pdvm_back #(
  parameter int MAX_VOICES         = pdvm_pkg::MAX_VOICES_DEF,
  parameter int SINE_QUARTER_DEPTH = pdvm_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pdvm_pkg::cfg_t                    cfg,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  pdvm_pkg::item_t                   item,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pdvm_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int IDX_W = MAX_VOICES > 1 ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int POS_W = $clog2(SINE_QUARTER_DEPTH + 1);
  localparam int VW    = $bits(pdvm_pkg::voice_t);
  localparam int DW    = pdvm_pkg::DIV_W;

  // quarter-wave sine table
  logic [14:0] sine_tbl [SINE_QUARTER_DEPTH + 1];
  for (genvar k = 0; k <= SINE_QUARTER_DEPTH; k++) begin : g_tbl
    assign sine_tbl[k] =
      pdvm_pkg::sine_entry((pdvm_pkg::HALF_PI_Q30 * 64'(k)) / SINE_QUARTER_DEPTH);
  end

  pdvm_pkg::state_t state, state_next;

  // item fields
  logic                              shape_r;
  logic [pdvm_pkg::VOLUME_W-1:0]     gain_r;
  logic [pdvm_pkg::DURATION_W-1:0]   dur_r;
  logic [pdvm_pkg::MAX_PITCH_W+pdvm_pkg::PITCH_W-1:0] prod;

  // dividers
  logic [DW-1:0]                     num_p, num_d;
  logic [pdvm_pkg::SAMPLE_RATE_W:0]  rem_p, tp, rem_p_next;
  logic [pdvm_pkg::DURATION_W:0]     rem_d, td, rem_d_next;
  logic [pdvm_pkg::PHASE_W-1:0]      quo_p;
  logic [pdvm_pkg::DECAY_W-1:0]      quo_d;
  logic                              ge_p, ge_d;
  logic [pdvm_pkg::DIV_CNT_W-1:0]    div_cnt;
  logic [pdvm_pkg::SAMPLE_RATE_W-1:0] sr_eff;
  logic [pdvm_pkg::DURATION_W-1:0]   dur_eff;

  // free slot scan
  logic [CNT_W-1:0] scan_idx;
  logic             found;
  logic             scan_done;
  logic             push_end;

  // voice bank
  logic [MAX_VOICES-1:0] live;
  logic [CNT_W-1:0]      live_cnt;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  pdvm_pkg::voice_t      ram_wdata, rd;

  // tick pipeline
  logic [CNT_W-1:0]      iss_idx;
  logic                  issue;
  logic                  v1, v2, v3, v4;
  logic [IDX_W-1:0]      idx1;
  logic signed [15:0]    w2;
  logic [15:0]           g2;
  logic signed [pdvm_pkg::ENV_W-1:0] e2, e3;
  logic signed [31:0]    p3;
  logic signed [57:0]    p4;
  logic signed [63:0]    sum;
  logic                  tick_end;

  // wave
  logic [1:0]            quad;
  logic [POS_W-1:0]      pos, sidx;
  logic signed [15:0]    mag, sine_w, tri_w, wave;
  logic [31:0]           u;
  logic signed [17:0]    tdown;
  logic signed [pdvm_pkg::ENV_W-1:0] env_new;
  logic                  freed;

  // result
  logic [15:0]           res_sample;
  logic                  res_acc;
  logic                  neg, over, under;
  logic [63:0]           smag;
  logic [15:0]           q16, sat_sample;
  logic [pdvm_pkg::LIVE_W-1:0] live_sat;
  logic                  out_load;

  pdvm_ram #(.WIDTH(VW), .DEPTH(MAX_VOICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // dividers, one quotient bit per cycle
  always_comb begin
    sr_eff  = (cfg.sample_rate == '0) ? pdvm_pkg::SAMPLE_RATE_W'(1) : cfg.sample_rate;
    dur_eff = (dur_r == '0) ? pdvm_pkg::DURATION_W'(1) : dur_r;
    tp = {rem_p[pdvm_pkg::SAMPLE_RATE_W-1:0], num_p[DW-1]};
    ge_p = tp >= {1'b0, sr_eff};
    rem_p_next = ge_p ? tp - {1'b0, sr_eff} : tp;
    td = {rem_d[pdvm_pkg::DURATION_W-1:0], num_d[DW-1]};
    ge_d = td >= {1'b0, dur_eff};
    rem_d_next = ge_d ? td - {1'b0, dur_eff} : td;
    scan_done = found || (scan_idx == CNT_W'(MAX_VOICES));
    push_end = (div_cnt == '0) && scan_done;
  end

  // wave and envelope of the slot just read
  always_comb begin
    quad = rd.phase[31:30];
    pos = POS_W'((64'(rd.phase[29:0]) * SINE_QUARTER_DEPTH) >> 30);
    sidx = quad[0] ? POS_W'(SINE_QUARTER_DEPTH) - pos : pos;
    mag = $signed({1'b0, sine_tbl[sidx]});
    sine_w = quad[1] ? -mag : mag;
    u = rd.phase + 32'h4000_0000;
    tdown = 18'sd98304 - $signed({1'b0, u[31:15]});
    if (!u[31]) tri_w = $signed({~u[30], u[29:15]});
    else if (tdown > 18'sd32767) tri_w = 16'sd32767;
    else tri_w = 16'(tdown);
    wave = rd.shape ? tri_w : sine_w;
    env_new = rd.env - $signed({1'b0, rd.decay});
    freed = env_new[pdvm_pkg::ENV_W-1];
    issue = (iss_idx != CNT_W'(MAX_VOICES));
    tick_end = !issue && !v1 && !v2 && !v3 && !v4;
  end

  // saturation of the Q8.55 sum
  always_comb begin
    neg = sum[63];
    smag = neg ? 64'(-sum) : 64'(sum);
    over = !neg && (sum[62:55] != '0);
    under = neg && ((smag[63:56] != '0) || (smag[55] && (smag[54:0] != '0)));
    q16 = smag[55:40];
    if (over) sat_sample = 16'h7FFF;
    else if (under) sat_sample = 16'h8000;
    else if (neg) sat_sample = -q16;
    else sat_sample = q16;
    live_sat = (32'(live_cnt) > 32'd63) ? 6'd63 : pdvm_pkg::LIVE_W'(live_cnt);
  end

  always_comb begin
    state_next = state;
    case (state)
      pdvm_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = (item.op == pdvm_pkg::OP_PUSH) ? pdvm_pkg::ST_PUSH_MUL
                                                       : pdvm_pkg::ST_TICK;
        end
      end
      pdvm_pkg::ST_PUSH_MUL: state_next = pdvm_pkg::ST_PUSH_DIV;
      pdvm_pkg::ST_PUSH_DIV: if (push_end) state_next = pdvm_pkg::ST_FINISH;
      pdvm_pkg::ST_TICK: if (tick_end) state_next = pdvm_pkg::ST_TICK_SAT;
      pdvm_pkg::ST_TICK_SAT: state_next = pdvm_pkg::ST_FINISH;
      pdvm_pkg::ST_FINISH: if (!m_tvalid || m_tready) state_next = pdvm_pkg::ST_IDLE;
      default: state_next = pdvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == pdvm_pkg::ST_IDLE);
    out_load = (state == pdvm_pkg::ST_FINISH) && (!m_tvalid || m_tready);
    ram_raddr = iss_idx[IDX_W-1:0];
    ram_we = 1'b0;
    ram_waddr = idx1;
    ram_wdata = rd;
    case (state)
      pdvm_pkg::ST_PUSH_DIV: begin
        ram_we = push_end && found;
        ram_waddr = scan_idx[IDX_W-1:0];
        ram_wdata.shape = shape_r;
        ram_wdata.gain  = gain_r;
        ram_wdata.phase = '0;
        ram_wdata.step  = quo_p;
        ram_wdata.env   = pdvm_pkg::ENV_W'(pdvm_pkg::ENV_ONE);
        ram_wdata.decay = quo_d;
      end
      pdvm_pkg::ST_TICK: begin
        ram_we = v1;
        ram_wdata.env = env_new;
        ram_wdata.phase = rd.phase + rd.step;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pdvm_pkg::ST_IDLE;
      live     <= '0;
      live_cnt <= '0;
      m_tvalid <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      found    <= 1'b0;
      scan_idx <= '0;
      iss_idx  <= '0;
      div_cnt  <= '0;
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        pdvm_pkg::ST_IDLE: begin
          found    <= 1'b0;
          scan_idx <= '0;
          iss_idx  <= '0;
          div_cnt  <= pdvm_pkg::DIV_CNT_W'(DW);
        end
        pdvm_pkg::ST_PUSH_MUL, pdvm_pkg::ST_PUSH_DIV: begin
          if (!scan_done) begin
            if (!live[scan_idx[IDX_W-1:0]]) found <= 1'b1;
            else scan_idx <= scan_idx + 1'b1;
          end
          if (state == pdvm_pkg::ST_PUSH_DIV) begin
            if (div_cnt != '0) div_cnt <= div_cnt - 1'b1;
            if (push_end && found) begin
              live[scan_idx[IDX_W-1:0]] <= 1'b1;
              live_cnt <= live_cnt + 1'b1;
            end
          end
        end
        pdvm_pkg::ST_TICK: begin
          v1 <= issue && live[iss_idx[IDX_W-1:0]];
          v2 <= v1;
          v3 <= v2;
          v4 <= v3;
          if (issue) iss_idx <= iss_idx + 1'b1;
          if (v1 && freed) begin
            live[idx1] <= 1'b0;
            live_cnt <= live_cnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == pdvm_pkg::ST_IDLE && item_valid) begin
      shape_r    <= item.shape;
      gain_r     <= item.volume;
      dur_r      <= item.duration;
      prod       <= cfg.max_pitch * item.pitch;
      sum        <= '0;
      res_sample <= '0;
      res_acc    <= 1'b0;
    end
    if (state == pdvm_pkg::ST_PUSH_MUL) begin
      num_p <= {prod, 16'b0};
      num_d <= DW'(pdvm_pkg::ENV_ONE);
      rem_p <= '0;
      rem_d <= '0;
      quo_p <= '0;
      quo_d <= '0;
    end
    if (state == pdvm_pkg::ST_PUSH_DIV) begin
      if (div_cnt != '0) begin
        num_p <= num_p << 1;
        num_d <= num_d << 1;
        rem_p <= rem_p_next;
        rem_d <= rem_d_next;
        quo_p <= {quo_p[pdvm_pkg::PHASE_W-2:0], ge_p};
        quo_d <= {quo_d[pdvm_pkg::DECAY_W-2:0], ge_d};
      end
      if (push_end) res_acc <= found;
    end
    if (state == pdvm_pkg::ST_TICK) begin
      idx1 <= iss_idx[IDX_W-1:0];
      w2   <= wave;
      g2   <= rd.gain;
      e2   <= rd.env;
      p3   <= 32'(w2 * $signed({1'b0, g2}));
      e3   <= e2;
      p4   <= 58'(p3 * e3);
      if (v4) sum <= sum + 64'(p4);
    end
    if (state == pdvm_pkg::ST_TICK_SAT) res_sample <= sat_sample;
    if (out_load) m_tdata <= {1'b0, live_sat, res_acc, res_sample};
  end

endmodule

/* rtl/polyphonic_decay_voice_mixer.sv */
// Polyphonic voice mixer. A push request (tuser 0) claims the lowest free voice
// slot; a tick request (tuser 1) mixes all live voices into one saturated
// 16-bit sample and ages their envelopes. Every request gives exactly one
// result. A push waits for both the bit-serial phase-step and decay dividers
// (one quotient bit per cycle) and the free-slot scan to finish. A tick reads
// the voice RAM one slot per cycle and then drains the multiply/accumulate
// pipeline. A two-entry input queue takes requests while one is in work.
// Config writes are taken at any time but should only be issued while idle.
module polyphonic_decay_voice_mixer #(
  parameter int MAX_VOICES         = pdvm_pkg::MAX_VOICES_DEF,
  parameter int SINE_QUARTER_DEPTH = pdvm_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // wave_shape, voice_volume, pitch_fraction, duration_samples, zero pad
  input  logic [pdvm_pkg::IN_DATA_W-1:0]    s_tdata,
  // operation
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sample_out, push_accepted, live_voices, zero pad
  output logic [pdvm_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pdvm_pkg::cfg_t  cfg;
  pdvm_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_pitch   <= pdvm_pkg::MAX_PITCH_RST;
      cfg.sample_rate <= pdvm_pkg::SAMPLE_RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdvm_pkg::CFG_MAX_PITCH:   cfg.max_pitch <= cfg_data[pdvm_pkg::MAX_PITCH_W-1:0];
        pdvm_pkg::CFG_SAMPLE_RATE: cfg.sample_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  pdvm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  pdvm_back #(
    .MAX_VOICES         (MAX_VOICES),
    .SINE_QUARTER_DEPTH (SINE_QUARTER_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

/* rtl/pdvm_checker.sv */
`include "polyphonic_decay_voice_mixer_assert.svh"

module pdvm_checker #(
  parameter int MAX_VOICES = pdvm_pkg::MAX_VOICES_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pdvm_pkg::OUT_DATA_W-1:0] m_tdata
);

  `PDVM_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `PDVM_ASSERT(a_push_silent, clk, rst, m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
  `PDVM_ASSERT(a_live_bound, clk, rst, m_tvalid |-> (32'(m_tdata[22:17]) <= MAX_VOICES) || (MAX_VOICES > 63))
  `PDVM_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_tvalid)

endmodule

bind polyphonic_decay_voice_mixer pdvm_checker #(.MAX_VOICES(MAX_VOICES)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int NVOICE = pdvm_pkg::MAX_VOICES_DEF;
  localparam int QDEPTH = pdvm_pkg::SINE_DEPTH_DEF;
  localparam logic [pdvm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [pdvm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {DUR_SHORT, DUR_MIXED, DUR_ANY} dur_mode_t;

  typedef struct {
    pdvm_pkg::op_t                   op;
    logic                            shape;
    logic [pdvm_pkg::VOLUME_W-1:0]   volume;
    logic [pdvm_pkg::PITCH_W-1:0]    pitch;
    logic [pdvm_pkg::DURATION_W-1:0] duration;
  } voice_req_t;

  typedef struct {
    logic [pdvm_pkg::SAMPLE_W-1:0] sample;
    logic                          accepted;
    logic [pdvm_pkg::LIVE_W-1:0]   live;
  } mix_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [pdvm_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [pdvm_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pdvm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pdvm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  polyphonic_decay_voice_mixer i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mixer model state
  logic [pdvm_pkg::MAX_PITCH_W-1:0]   pitch_hz;
  logic [pdvm_pkg::SAMPLE_RATE_W-1:0] rate_hz;
  bit                       v_live[NVOICE];
  logic                     v_shape[NVOICE];
  logic [15:0]              v_gain[NVOICE];
  logic [31:0]              v_phase[NVOICE];
  logic [31:0]              v_step[NVOICE];
  int                       v_env[NVOICE];
  logic [31:0]              v_decay[NVOICE];
  int                       sine_tab[QDEPTH+1];

  voice_req_t pending_reqs[$];
  mix_out_t   expected_mix[$];
  voice_req_t cur_req;
  bit  req_taken = 0;
  int  req_gap = 0;
  bit  res_taken = 0;
  int  res_gap = 0;
  int  hold_cycles = 0;
  bit  calm = 0;
  int  errors = 0;
  int  cycles = 0;

  function automatic int quarter_sine(longint unsigned k);
    longint unsigned x, x2, term, v;
    longint s;
    x = (64'd1686629713 * k) / QDEPTH;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    v = (unsigned'(s) * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  function automatic int wave_at(logic shape, logic [31:0] ph);
    logic [31:0] u;
    int pos, mag, w;
    if (shape) begin
      u = ph + 32'h4000_0000;
      if (u < 32'h8000_0000) w = int'(u >> 15) - 32768;
      else begin
        w = 98304 - int'(u >> 15);
        if (w > 32767) w = 32767;
      end
      return w;
    end
    pos = int'((longint'(ph[29:0]) * QDEPTH) >> 30);
    mag = ph[30] ? sine_tab[QDEPTH - pos] : sine_tab[pos];
    return ph[31] ? -mag : mag;
  endfunction

  function automatic mix_out_t mix_step(voice_req_t r);
    mix_out_t o;
    int slot, cnt, w;
    longint sum, den;
    longint unsigned dur;
    o.sample = '0;
    o.accepted = 1'b0;
    if (r.op == pdvm_pkg::OP_PUSH) begin
      slot = -1;
      for (int i = NVOICE - 1; i >= 0; i--) if (!v_live[i]) slot = i;
      if (slot >= 0) begin
        den = (rate_hz == 0) ? 1 : longint'(rate_hz);
        dur = (r.duration == 0) ? 1 : r.duration;
        v_live[slot] = 1;
        v_shape[slot] = r.shape;
        v_gain[slot] = r.volume;
        v_phase[slot] = '0;
        v_step[slot] = 32'(((longint'(pitch_hz) * longint'(r.pitch)) << 16) / den);
        v_env[slot] = pdvm_pkg::ENV_ONE;
        v_decay[slot] = 32'((64'd1 << 24) / dur);
        o.accepted = 1'b1;
      end
    end else begin
      sum = 0;
      for (int i = 0; i < NVOICE; i++) begin
        if (!v_live[i]) continue;
        w = wave_at(v_shape[i], v_phase[i]);
        sum += longint'(w) * longint'(v_gain[i]) * longint'(v_env[i]);
        v_env[i] -= int'(v_decay[i]);
        if (v_env[i] < 0) v_live[i] = 0;
        else v_phase[i] += v_step[i];
      end
      if (sum >= (64'sd1 << 55)) o.sample = 16'h7FFF;
      else if (sum < -(64'sd1 << 55)) o.sample = 16'h8000;
      else o.sample = 16'(sum / (64'sd1 << 40));
    end
    cnt = 0;
    for (int i = 0; i < NVOICE; i++) cnt += v_live[i];
    o.live = (cnt > 63) ? 6'd63 : pdvm_pkg::LIVE_W'(cnt);
    return o;
  endfunction

  function automatic void add_req(voice_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // request side
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_mix.insert(expected_mix.size(), mix_step(cur_req));
      req_taken = 1;
    end
  end

  always @(negedge clk) begin
    logic nxt;
    nxt = s_tvalid && !req_taken;
    if (!rst && !nxt) begin
      req_taken = 0;
      if (req_gap > 0) req_gap--;
      else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_tdata <= {7'd0, cur_req.duration, cur_req.pitch, cur_req.volume, cur_req.shape};
        s_tuser <= cur_req.op;
        nxt = 1'b1;
        req_gap = calm ? 0 : $urandom_range(0, 7);
      end
    end
    s_tvalid <= nxt;
  end

  // result side
  always @(posedge clk) begin
    mix_out_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      res_taken = 1;
      if (expected_mix.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        e = expected_mix.pop_front();
        if (m_tdata[15:0] !== e.sample || m_tdata[16] !== e.accepted ||
            m_tdata[22:17] !== e.live || m_tdata[23] !== 1'b0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp sample %h acc %b live %0d, got sample %h acc %b live %0d",
                     e.sample, e.accepted, e.live, m_tdata[15:0], m_tdata[16],
                     m_tdata[22:17]);
        end
      end
    end
  end

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (res_taken) begin
      res_taken = 0;
      res_gap = calm ? 0 : $urandom_range(0, 7);
    end
    if (!rst) begin
      if (hold_cycles > 0) hold_cycles--;
      else if (res_gap > 0) res_gap--;
      else rdy = 1'b1;
    end
    m_tready <= rdy;
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_tvalid || expected_mix.size() != 0 || hold_cycles != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [pdvm_pkg::CFG_IDX_W-1:0] idx,
                           logic [pdvm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pdvm_pkg::CFG_MAX_PITCH) pitch_hz = val[pdvm_pkg::MAX_PITCH_W-1:0];
    else if (idx == pdvm_pkg::CFG_SAMPLE_RATE) rate_hz = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic voice_req_t make_req(pdvm_pkg::op_t op, logic sh, int vol, int pf,
                                          int dur);
    voice_req_t r;
    r.op = op;
    r.shape = sh;
    r.volume = pdvm_pkg::VOLUME_W'(vol);
    r.pitch = pdvm_pkg::PITCH_W'(pf);
    r.duration = pdvm_pkg::DURATION_W'(dur);
    return r;
  endfunction

  task automatic queue_random(int n, int push_pct, dur_mode_t mode);
    int dur, sel;
    pdvm_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      case (mode)
        DUR_SHORT: dur = $urandom_range(1, 300);
        DUR_MIXED: dur = (sel < 5) ? 0 : (sel < 15) ? $urandom_range(300, 3000)
                                                    : $urandom_range(1, 150);
        default: dur = $urandom;
      endcase
      op = ($urandom_range(0, 99) < push_pct) ? pdvm_pkg::OP_PUSH : pdvm_pkg::OP_TICK;
      add_req(make_req(op, $urandom_range(0, 1), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), dur));
    end
  endtask

  initial begin
    for (int k = 0; k <= QDEPTH; k++) sine_tab[k] = quarter_sine(k);
    pitch_hz = pdvm_pkg::MAX_PITCH_RST;
    rate_hz = pdvm_pkg::SAMPLE_RATE_RST;
    for (int i = 0; i < NVOICE; i++) v_live[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, zero duration, both shapes
    add_req(make_req(pdvm_pkg::OP_TICK, 0, 0, 0, 1));
    add_req(make_req(pdvm_pkg::OP_PUSH, 0, 65535, 65535, 1));
    add_req(make_req(pdvm_pkg::OP_PUSH, 1, 0, 0, 0));
    add_req(make_req(pdvm_pkg::OP_PUSH, 1, 65535, 65535, 16777215));
    add_req(make_req(pdvm_pkg::OP_PUSH, 0, 32768, 12345, 4));
    for (int i = 0; i < 4; i++) add_req(make_req(pdvm_pkg::OP_TICK, 0, 0, 0, 1));
    add_req(make_req(pdvm_pkg::OP_PUSH, 1, 65535, 1, 2));
    add_req(make_req(pdvm_pkg::OP_PUSH, 0, 65535, 65535, 10));
    for (int i = 0; i < 4; i++) add_req(make_req(pdvm_pkg::OP_TICK, 0, 0, 0, 1));
    wait_idle();

    // fast pitch, fast rate; receiver held off to back up the input
    write_reg(pdvm_pkg::CFG_MAX_PITCH, 18'd20000);
    write_reg(pdvm_pkg::CFG_SAMPLE_RATE, 18'd192000);
    hold_cycles = 600;
    queue_random(230, 50, DUR_MIXED);
    wait_idle();

    write_reg(pdvm_pkg::CFG_MAX_PITCH, 18'd1);
    write_reg(pdvm_pkg::CFG_SAMPLE_RATE, 18'd8000);
    calm = 1;
    queue_random(220, 40, DUR_SHORT);
    wait_idle();
    calm = 0;

    // wrapping phase step; unused indexes and upper data bits are ignored
    write_reg(pdvm_pkg::CFG_MAX_PITCH, 18'h3_4E20);
    write_reg(pdvm_pkg::CFG_SAMPLE_RATE, 18'd8000);
    write_reg(CFG_SPARE_A, 18'h3_FFFF);
    write_reg(CFG_SPARE_B, 18'd0);
    queue_random(220, 60, DUR_MIXED);
    wait_idle();

    // zero sample rate and zero pitch
    write_reg(pdvm_pkg::CFG_SAMPLE_RATE, 18'd0);
    queue_random(100, 45, DUR_SHORT);
    wait_idle();
    write_reg(pdvm_pkg::CFG_MAX_PITCH, 18'd0);
    write_reg(pdvm_pkg::CFG_SAMPLE_RATE, 18'h3_FFFF);
    queue_random(100, 45, DUR_SHORT);
    wait_idle();

    write_reg(pdvm_pkg::CFG_MAX_PITCH, 18'h7FFF);
    write_reg(pdvm_pkg::CFG_SAMPLE_RATE, 18'd44100);
    queue_random(200, 45, DUR_MIXED);
    wait_idle();

    // long voices fill the bank so pushes get dropped
    write_reg(pdvm_pkg::CFG_MAX_PITCH, 18'd1320);
    queue_random(270, 60, DUR_ANY);
    wait_idle();

    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
